### rtl/core/yphc_pkg.sv
// Shared types and constants of the yaw heading PID controller.
// Used by yphc_mac, yphc_div and yaw_pid_heading_controller_top; depends on nothing.
`timescale 1ns / 1ps

package yphc_pkg;

	// Integral state width and the widths that follow from it.
	localparam int INTEGRAL_WIDTH = 48;
	localparam int INT_SHIFT      = 16;
	localparam int MUL_W          = (INTEGRAL_WIDTH - INT_SHIFT > 33) ?
	                                (INTEGRAL_WIDTH - INT_SHIFT) : 33;
	localparam int PROD_W         = 2 * MUL_W;
	localparam int ACC_W          = (INTEGRAL_WIDTH + 3 > 52) ? (INTEGRAL_WIDTH + 3) : 52;

	// Field widths.
	localparam int TIME_W  = 32;
	localparam int ANGLE_W = 15;
	localparam int POS_W   = 24;
	localparam int GAIN_W  = 16;
	localparam int RATE_W  = 14;
	localparam int PERR_W  = 16;
	localparam int IN_W    = 136;
	localparam int OUT_W   = 32;
	localparam int CFG_W   = 24;
	localparam int CFG_IDX_W = 3;

	// Divider widths: the dividend is |error delta| * 2^16, the divisor is time + 1.
	localparam int DIVIDEND_W = 32;
	localparam int DIVISOR_W  = 33;

	// Angle and limit constants in Q3.12, rates in Q.20.
	localparam int PI_Q12      = 12868;
	localparam int TWO_PI_Q12  = 25736;
	localparam int ALIGN_LIMIT = 3216;
	localparam int NEAR_SHIFT  = 20;
	localparam int RATE_SHIFT  = 20;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_GOAL_X       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GOAL_Z       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GOAL_HEADING = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd6;

	localparam logic [GAIN_W-1:0] GAIN_P_RESET = 16'd384;

	// Command to the multiply-accumulate unit.
	typedef struct packed {
		logic valid;  // issue a product this cycle
		logic first;  // the product starts a new accumulation
	} mac_cmd_t;

endpackage

### rtl/core/yphc_mac.sv
// Shared multiply-accumulate unit: one registered signed multiplier and an accumulator.
// Depends on yphc_pkg.
`timescale 1ns / 1ps

module yphc_mac (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  yphc_pkg::mac_cmd_t                   cmd,
	input  logic signed [yphc_pkg::MUL_W-1:0]    op_a,
	input  logic signed [yphc_pkg::MUL_W-1:0]    op_b,
	output logic signed [yphc_pkg::ACC_W-1:0]    acc
);
	import yphc_pkg::*;

	logic signed [PROD_W-1:0] prod_full;
	logic signed [ACC_W-1:0]  prod_s1;
	logic                     add_s1;
	logic                     first_s1;
	logic signed [ACC_W-1:0]  acc_q;

	assign prod_full = op_a * op_b;

	// Every product this block forms fits the accumulator width.
	always_ff @(posedge clk) begin
		prod_s1 <= prod_full[ACC_W-1:0];
		if (add_s1) begin
			acc_q <= first_s1 ? prod_s1 : acc_q + prod_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_s1   <= 1'b0;
			first_s1 <= 1'b0;
		end else begin
			add_s1   <= cmd.valid;
			first_s1 <= cmd.first;
		end
	end

	assign acc = acc_q;

endmodule

### rtl/core/yphc_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on yphc_pkg.
`timescale 1ns / 1ps

module yphc_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [yphc_pkg::DIVIDEND_W-1:0]     dividend,
	input  logic [yphc_pkg::DIVISOR_W-1:0]      divisor,
	output logic                                busy,
	output logic [yphc_pkg::DIVIDEND_W-1:0]     quotient
);
	import yphc_pkg::*;

	localparam int CNT_W = $clog2(DIVIDEND_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  den_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic [DIVISOR_W-1:0]  rem_sh;
	logic                  fits;

	// The remainder stays below the divisor, so its top bit is always clear.
	assign rem_sh = {rem_q[DIVISOR_W-2:0], quo_q[DIVIDEND_W-1]};
	assign fits   = (rem_sh >= den_q);

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? (rem_sh - den_q) : rem_sh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

### rtl/core/yaw_pid_heading_controller_top.sv
// Top level of the yaw heading PID controller: sequencer, state and handshakes.
// Depends on yphc_pkg, yphc_mac and yphc_div.
`timescale 1ns / 1ps

// The block takes one request on the slave stream (s_tvalid/s_tready/s_tdata) holding the
// step time, the robot yaw, the trajectory yaw and the robot position, and returns one
// result on the master stream (m_tvalid/m_tready/m_tdata) with the wrapped heading error,
// the clamped turn rate and the near-goal and aligned flags.
// The user must write goal position, goal yaw and the three gains (cfg_we, cfg_index,
// cfg_data) only while the block is idle (not enforced); indexes above six are ignored.
// All products go through one shared multiply-accumulate unit under a small sequencer:
// three squares for the goal distance, error times time for the integral, and the three
// gain terms. The derivative quotient comes from a 32-step restoring divider, which sets
// the pace. s_tready is high only while the sequencer is idle, so the next request is
// accepted only after the result has been written to the output register.
// The result sits in an output register. If the receiver stalls, the block still accepts
// and works on the next request and waits at its final step until the register frees up.
// Reset clears the integral and the previous error, loads the register reset values
// (proportional gain 1.5, everything else zero) and empties the output register.

module yaw_pid_heading_controller_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// s_tdata, from bit 0: time_value[31:0], robot_heading[46:32], target_heading[61:47],
	// robot_x[85:62], robot_y[109:86], robot_z[133:110], zero fill[135:134]
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [yphc_pkg::IN_W-1:0]             s_tdata,
	// m_tdata, from bit 0: heading_error[14:0], turn_rate[28:15], near_goal[29],
	// heading_aligned[30], zero fill[31]
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [yphc_pkg::OUT_W-1:0]            m_tdata,
	input  logic                                  cfg_we,
	input  logic [yphc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [yphc_pkg::CFG_W-1:0]            cfg_data
);
	import yphc_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SQX  = 4'd1;
	localparam logic [3:0] ST_SQY  = 4'd2;
	localparam logic [3:0] ST_SQZ  = 4'd3;
	localparam logic [3:0] ST_DIST = 4'd4;
	localparam logic [3:0] ST_ERR  = 4'd5;
	localparam logic [3:0] ST_INC  = 4'd6;
	localparam logic [3:0] ST_INCW = 4'd7;
	localparam logic [3:0] ST_INT  = 4'd8;
	localparam logic [3:0] ST_MI   = 4'd9;
	localparam logic [3:0] ST_WDIV = 4'd10;
	localparam logic [3:0] ST_ACC  = 4'd11;
	localparam logic [3:0] ST_OUT  = 4'd12;

	localparam int IW = INTEGRAL_WIDTH;

	// Saturation bounds of the integral, at the width of the integral sum.
	localparam logic signed [ACC_W:0] SAT_HI = {{(ACC_W - IW + 2){1'b0}}, {(IW - 1){1'b1}}};
	localparam logic signed [ACC_W:0] SAT_LO = {{(ACC_W - IW + 2){1'b1}}, {(IW - 1){1'b0}}};
	localparam logic signed [ACC_W-1:0] RATE_HI = ACC_W'(1) <<< RATE_SHIFT;
	localparam logic signed [ACC_W-1:0] RATE_LO = -RATE_HI;
	localparam logic signed [PERR_W-1:0] PI_W     = PERR_W'(PI_Q12);
	localparam logic signed [PERR_W-1:0] TWO_PI_W = PERR_W'(TWO_PI_Q12);
	localparam logic signed [ANGLE_W-1:0] ALIGN_W = ANGLE_W'(ALIGN_LIMIT);

	logic [3:0] state_q;

	// Configuration registers.
	logic signed [POS_W-1:0]   goal_x_q, goal_y_q, goal_z_q;
	logic signed [ANGLE_W-1:0] goal_heading_q;
	logic signed [GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;

	// Latched request fields.
	logic [TIME_W-1:0]         time_q;
	logic signed [ANGLE_W-1:0] robot_heading_q, target_heading_q;
	logic signed [POS_W-1:0]   robot_x_q, robot_y_q, robot_z_q;

	// Controller state and per-request intermediates.
	logic signed [IW-1:0]      integral_q;
	logic signed [PERR_W-1:0]  prev_error_q;
	logic signed [ANGLE_W-1:0] error_q;
	logic                      near_q;
	logic                      de_neg_q;

	logic                      m_tvalid_q;
	logic [OUT_W-1:0]          m_tdata_q;

	// Shared unit connections.
	mac_cmd_t                  mac_cmd;
	logic signed [MUL_W-1:0]   mac_a, mac_b;
	logic signed [ACC_W-1:0]   mac_acc;
	logic                      div_start;
	logic [DIVIDEND_W-1:0]     div_dividend;
	logic [DIVISOR_W-1:0]      div_divisor;
	logic                      div_busy;
	logic [DIVIDEND_W-1:0]     div_quo;

	// Combinational helpers.
	logic signed [POS_W:0]     dx, dy, dz;
	logic signed [ANGLE_W-1:0] desired;
	logic signed [PERR_W-1:0]  raw_err;
	logic signed [PERR_W-1:0]  wrap_err;
	logic                      near_now;
	logic signed [PERR_W:0]    de;
	logic [PERR_W:0]           de_mag;
	logic signed [IW-INT_SHIFT-1:0] int_sh;
	logic signed [DIVISOR_W-1:0] d_mag, d_val;
	logic signed [ACC_W:0]     int_sum;
	logic signed [IW-1:0]      int_next;
	logic signed [ACC_W-1:0]   rate_clamp;
	logic [RATE_W-1:0]         turn_rate;
	logic                      aligned;
	logic                      out_free;

	assign dx = {goal_x_q[POS_W-1], goal_x_q} - {robot_x_q[POS_W-1], robot_x_q};
	assign dy = {goal_y_q[POS_W-1], goal_y_q} - {robot_y_q[POS_W-1], robot_y_q};
	assign dz = {goal_z_q[POS_W-1], goal_z_q} - {robot_z_q[POS_W-1], robot_z_q};

	// After the three squares the accumulator holds the squared distance, never negative.
	assign near_now = (mac_acc[ACC_W-1:NEAR_SHIFT] == '0);
	assign desired  = near_now ? goal_heading_q : target_heading_q;
	assign raw_err  = {desired[ANGLE_W-1], desired} -
	                  {robot_heading_q[ANGLE_W-1], robot_heading_q};

	// A single wrap correction.
	always_comb begin
		if (raw_err > PI_W) begin
			wrap_err = raw_err - TWO_PI_W;
		end else if (raw_err < -PI_W) begin
			wrap_err = raw_err + TWO_PI_W;
		end else begin
			wrap_err = raw_err;
		end
	end

	assign de     = {{2{error_q[ANGLE_W-1]}}, error_q} - {prev_error_q[PERR_W-1], prev_error_q};
	assign de_mag = de[PERR_W] ? (PERR_W + 1)'(-de) : de;

	assign div_start    = (state_q == ST_INC);
	assign div_dividend = {de_mag[PERR_W-1:0], 16'd0};
	assign div_divisor  = {1'b0, time_q} + DIVISOR_W'(1);

	assign int_sh = integral_q[IW-1:INT_SHIFT];
	assign d_mag  = {1'b0, div_quo};
	assign d_val  = de_neg_q ? -d_mag : d_mag;

	// Operand selection for the shared multiplier.
	always_comb begin
		mac_cmd = '0;
		mac_a   = '0;
		mac_b   = '0;
		case (state_q)
			ST_SQX: begin
				mac_cmd = '{valid: 1'b1, first: 1'b1};
				mac_a   = MUL_W'(dx);
				mac_b   = MUL_W'(dx);
			end
			ST_SQY: begin
				mac_cmd = '{valid: 1'b1, first: 1'b0};
				mac_a   = MUL_W'(dy);
				mac_b   = MUL_W'(dy);
			end
			ST_SQZ: begin
				mac_cmd = '{valid: 1'b1, first: 1'b0};
				mac_a   = MUL_W'(dz);
				mac_b   = MUL_W'(dz);
			end
			ST_INC: begin
				mac_cmd = '{valid: 1'b1, first: 1'b1};
				mac_a   = MUL_W'(error_q);
				mac_b   = MUL_W'(signed'({1'b0, time_q}));
			end
			ST_INT: begin
				mac_cmd = '{valid: 1'b1, first: 1'b1};
				mac_a   = MUL_W'(gain_p_q);
				mac_b   = MUL_W'(error_q);
			end
			ST_MI: begin
				mac_cmd = '{valid: 1'b1, first: 1'b0};
				mac_a   = MUL_W'(gain_i_q);
				mac_b   = MUL_W'(int_sh);
			end
			ST_WDIV: begin
				mac_cmd = '{valid: !div_busy, first: 1'b0};
				mac_a   = MUL_W'(gain_d_q);
				mac_b   = MUL_W'(d_val);
			end
			default: begin
				mac_cmd = '0;
			end
		endcase
	end

	// Integral update: in the integral step the accumulator holds error times time.
	assign int_sum = (ACC_W + 1)'(integral_q) + (ACC_W + 1)'(mac_acc);
	always_comb begin
		if (int_sum > SAT_HI) begin
			int_next = SAT_HI[IW-1:0];
		end else if (int_sum < SAT_LO) begin
			int_next = SAT_LO[IW-1:0];
		end else begin
			int_next = int_sum[IW-1:0];
		end
	end

	// Rate: clamp the Q.20 sum to one rad/s and drop eight fraction bits.
	always_comb begin
		if (mac_acc > RATE_HI) begin
			rate_clamp = RATE_HI;
		end else if (mac_acc < RATE_LO) begin
			rate_clamp = RATE_LO;
		end else begin
			rate_clamp = mac_acc;
		end
	end
	assign turn_rate = rate_clamp[RATE_W+7:8];
	assign aligned   = (error_q < ALIGN_W) && (error_q > -ALIGN_W);
	assign out_free  = !m_tvalid_q || m_tready;

	yphc_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mac_cmd),
		.op_a   (mac_a),
		.op_b   (mac_b),
		.acc    (mac_acc)
	);

	yphc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_SQX;
					end
				end
				ST_SQX:  state_q <= ST_SQY;
				ST_SQY:  state_q <= ST_SQZ;
				ST_SQZ:  state_q <= ST_DIST;
				ST_DIST: state_q <= ST_ERR;
				ST_ERR:  state_q <= ST_INC;
				ST_INC:  state_q <= ST_INCW;
				ST_INCW: state_q <= ST_INT;
				ST_INT:  state_q <= ST_MI;
				ST_MI:   state_q <= ST_WDIV;
				ST_WDIV: begin
					if (!div_busy) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC:  state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request fields are captured on acceptance; error and flags in their own steps.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			time_q           <= s_tdata[31:0];
			robot_heading_q  <= s_tdata[46:32];
			target_heading_q <= s_tdata[61:47];
			robot_x_q        <= s_tdata[85:62];
			robot_y_q        <= s_tdata[109:86];
			robot_z_q        <= s_tdata[133:110];
		end
		if (state_q == ST_ERR) begin
			error_q <= wrap_err[ANGLE_W-1:0];
			near_q  <= near_now;
		end
		if (state_q == ST_INC) begin
			de_neg_q <= de[PERR_W];
		end
		if (state_q == ST_OUT && out_free) begin
			m_tdata_q <= {1'b0, aligned, near_q, turn_rate, error_q};
		end
	end

	// Controller state, configuration and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q     <= '0;
			prev_error_q   <= '0;
			m_tvalid_q     <= 1'b0;
			goal_x_q       <= '0;
			goal_y_q       <= '0;
			goal_z_q       <= '0;
			goal_heading_q <= '0;
			gain_p_q       <= GAIN_P_RESET;
			gain_i_q       <= '0;
			gain_d_q       <= '0;
		end else begin
			if (state_q == ST_INT) begin
				integral_q <= int_next;
			end
			if (state_q == ST_OUT && out_free) begin
				prev_error_q <= {error_q[ANGLE_W-1], error_q};
				m_tvalid_q   <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_GOAL_X:       goal_x_q       <= cfg_data[POS_W-1:0];
					REG_GOAL_Y:       goal_y_q       <= cfg_data[POS_W-1:0];
					REG_GOAL_Z:       goal_z_q       <= cfg_data[POS_W-1:0];
					REG_GOAL_HEADING: goal_heading_q <= cfg_data[ANGLE_W-1:0];
					REG_GAIN_P:       gain_p_q       <= cfg_data[GAIN_W-1:0];
					REG_GAIN_I:       gain_i_q       <= cfg_data[GAIN_W-1:0];
					REG_GAIN_D:       gain_d_q       <= cfg_data[GAIN_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
